/* rtl/sks_pkg.sv */
`default_nettype none

package sks_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int INDEX_W         = 10;
    localparam int COUNT_W         = 11;

    typedef struct packed {
        logic [7:0]  discipline;
        logic [7:0]  category;
        logic [7:0]  parameter_id;
        logic [15:0] template_number;
    } key_t;

    localparam int KEY_W = $bits(key_t);

    typedef struct packed {
        logic near;
        logic lt;
        logic gt;
    } cmp_res_t;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        STAT_EXACT   = 2'd0,
        STAT_NONE    = 2'd1,
        STAT_NEAR_LO = 2'd2,
        STAT_NEAR_HI = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_CMP,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

/* rtl/sks_ram.sv */
`default_nettype none

module sks_ram #(
    parameter int WIDTH = sks_pkg::KEY_W,
    parameter int DEPTH = sks_pkg::TABLE_DEPTH_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/sks_cmp.sv */
`default_nettype none

// key versus entry, full key order; near = first three keys equal
module sks_cmp (
    input  wire sks_pkg::key_t     key,
    input  wire sks_pkg::key_t     entry,
    output sks_pkg::cmp_res_t      res
);

    always_comb
    begin
        res.near = ({key.discipline, key.category, key.parameter_id} ==
                    {entry.discipline, entry.category, entry.parameter_id});
        res.lt   = (key < entry);
        res.gt   = (key > entry);
    end

endmodule

`default_nettype wire

/* rtl/sks_seq.sv */
`default_nettype none

module sks_seq #(
    parameter int TABLE_DEPTH = sks_pkg::TABLE_DEPTH_DEF,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int PTR_W = IDX_W + 1
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           in_kind,
    input  wire logic [sks_pkg::INDEX_W-1:0]    in_index,
    input  wire sks_pkg::key_t                  in_key,
    input  wire logic [PTR_W-1:0]               count,
    output logic                                wr_en,
    output logic      [IDX_W-1:0]               wr_addr,
    output sks_pkg::key_t                       wr_data,
    output logic                                rd_en,
    output logic      [IDX_W-1:0]               rd_addr,
    input  wire sks_pkg::key_t                  rd_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output sks_pkg::status_t                    out_status,
    output logic      [sks_pkg::INDEX_W-1:0]    out_index,
    output sks_pkg::key_t                       out_key
);

    localparam int CMP_W = (PTR_W > sks_pkg::COUNT_W) ? PTR_W : sks_pkg::COUNT_W;

    sks_pkg::state_t   state_reg, state_next;
    logic [PTR_W-1:0]  lo_reg, lo_next;
    logic [PTR_W-1:0]  hi_reg, hi_next;
    logic [IDX_W-1:0]  mid_reg, mid_next;
    sks_pkg::key_t     key_reg, key_next;
    logic              near_valid_reg, near_valid_next;
    logic              exact_reg, exact_next;
    logic              near_gt_reg, near_gt_next;
    logic [IDX_W-1:0]  near_idx_reg, near_idx_next;
    sks_pkg::key_t     near_key_reg, near_key_next;
    logic              out_valid_reg, out_valid_next;
    sks_pkg::status_t  out_status_reg, out_status_next;
    logic [sks_pkg::INDEX_W-1:0] out_index_reg, out_index_next;
    sks_pkg::key_t     out_key_reg, out_key_next;

    sks_pkg::cmp_res_t cmp_res;
    logic [PTR_W:0]    mid_sum;
    logic [CMP_W-1:0]  load_idx_ext;
    logic [CMP_W-1:0]  near_idx_ext;
    logic              accept;
    logic              out_free;

    sks_cmp u_cmp (
        .key   (key_reg),
        .entry (rd_data),
        .res   (cmp_res)
    );

    assign mid_sum      = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign load_idx_ext = CMP_W'(in_index);
    assign near_idx_ext = CMP_W'(near_idx_reg);
    assign accept       = in_valid && in_ready;
    assign out_free     = !out_valid_reg || out_ready;

    assign wr_addr = load_idx_ext[IDX_W-1:0];
    assign wr_data = in_key;
    assign rd_addr = mid_sum[IDX_W:1];

    always_comb
    begin
        state_next      = state_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        key_next        = key_reg;
        near_valid_next = near_valid_reg;
        exact_next      = exact_reg;
        near_gt_next    = near_gt_reg;
        near_idx_next   = near_idx_reg;
        near_key_next   = near_key_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_key_next    = out_key_reg;
        in_ready        = 1'b0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;

        unique case (state_reg)
            sks_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    if (in_kind == sks_pkg::KIND_LOAD)
                    begin
                        wr_en = (load_idx_ext < CMP_W'(TABLE_DEPTH));
                    end
                    else
                    begin
                        key_next        = in_key;
                        lo_next         = '0;
                        hi_next         = count;
                        near_valid_next = 1'b0;
                        exact_next      = 1'b0;
                        state_next      = sks_pkg::ST_ADDR;
                    end
                end
            end
            sks_pkg::ST_ADDR:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    mid_next   = mid_sum[IDX_W:1];
                    state_next = sks_pkg::ST_CMP;
                end
                else
                begin
                    state_next = sks_pkg::ST_DONE;
                end
            end
            sks_pkg::ST_CMP:
            begin
                if (cmp_res.near)
                begin
                    near_valid_next = 1'b1;
                    near_idx_next   = mid_reg;
                    near_key_next   = rd_data;
                    near_gt_next    = cmp_res.gt;
                end
                if (cmp_res.lt)
                begin
                    hi_next    = {1'b0, mid_reg};
                    state_next = sks_pkg::ST_ADDR;
                end
                else if (cmp_res.gt)
                begin
                    lo_next    = {1'b0, mid_reg} + PTR_W'(1);
                    state_next = sks_pkg::ST_ADDR;
                end
                else
                begin
                    exact_next = 1'b1;
                    state_next = sks_pkg::ST_DONE;
                end
            end
            sks_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (!near_valid_reg)
                    begin
                        out_status_next = sks_pkg::STAT_NONE;
                        out_index_next  = '0;
                        out_key_next    = '0;
                    end
                    else
                    begin
                        if (exact_reg)
                        begin
                            out_status_next = sks_pkg::STAT_EXACT;
                        end
                        else if (near_gt_reg)
                        begin
                            out_status_next = sks_pkg::STAT_NEAR_LO;
                        end
                        else
                        begin
                            out_status_next = sks_pkg::STAT_NEAR_HI;
                        end
                        out_index_next = near_idx_ext[sks_pkg::INDEX_W-1:0];
                        out_key_next   = near_key_reg;
                    end
                    state_next = sks_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sks_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sks_pkg::ST_IDLE;
            out_valid_reg  <= 1'b0;
            near_valid_reg <= 1'b0;
            exact_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            near_valid_reg <= near_valid_next;
            exact_reg      <= exact_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        key_reg        <= key_next;
        near_gt_reg    <= near_gt_next;
        near_idx_reg   <= near_idx_next;
        near_key_reg   <= near_key_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_key_reg    <= out_key_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_index  = out_index_reg;
    assign out_key    = out_key_reg;

    // compare only on data read in the cycle before
    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sks_pkg::ST_CMP) |-> $past(rd_en))
        else $error("compare without a read");

    a_mid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sks_pkg::ST_CMP) |->
            (({1'b0, mid_reg} >= lo_reg) && ({1'b0, mid_reg} < hi_reg)))
        else $error("probe outside search window");

    a_exact_is_near: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sks_pkg::ST_DONE && exact_reg) |-> near_valid_reg)
        else $error("exact hit without key match");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == sks_pkg::ST_DONE))
        else $error("result outside done state");

endmodule

`default_nettype wire

/* rtl/sorted_key_table_search.sv */
`default_nettype none

// Sorted key table search.
// Input channel (in_valid/in_ready): kind 0 loads an entry at entry_index
// (no result; indexes at or above TABLE_DEPTH are dropped); kind 1 looks up
// the key and returns exactly one result item.
// Config channel (cfg_valid/cfg_ready): writes entry_count, always ready;
// write it only while no lookup is in flight. Values above TABLE_DEPTH
// saturate.
// A lookup is a binary search over entries 0..entry_count-1, one probe at a
// time through the single table read port (address, then registered data
// into the key comparator), at most floor(log2(entry_count))+1 probes.
// The block takes one item at a time: a load frees the input at once, a
// lookup once its result is registered.
// The result sits in an output register; a new item is taken while it
// waits, and a finished lookup holds until out_ready frees the register.
// Reset clears control state and entry_count; table contents are
// undefined until loaded.
module sorted_key_table_search #(
    parameter int TABLE_DEPTH = sks_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [9:0]  entry_index,
    input  wire logic [7:0]  discipline,
    input  wire logic [7:0]  category,
    input  wire logic [7:0]  parameter_req,
    input  wire logic [15:0] template_number,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [9:0]       hit_index,
    output logic [7:0]       hit_discipline,
    output logic [7:0]       hit_category,
    output logic [7:0]       hit_parameter,
    output logic [15:0]      hit_template,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PTR_W = IDX_W + 1;
    localparam int CMP_W = (PTR_W > sks_pkg::COUNT_W) ? PTR_W : sks_pkg::COUNT_W;

    logic [sks_pkg::COUNT_W-1:0] entry_count_reg;
    logic [CMP_W-1:0]            count_ext;
    logic [CMP_W-1:0]            count_sat;
    logic [PTR_W-1:0]            count;

    sks_pkg::key_t    in_key;
    sks_pkg::key_t    out_key;
    sks_pkg::status_t out_status;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    sks_pkg::key_t    wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    sks_pkg::key_t    rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            entry_count_reg <= cfg_data;
        end
    end

    assign count_ext = CMP_W'(entry_count_reg);
    assign count_sat = (count_ext > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH) : count_ext;
    assign count     = count_sat[PTR_W-1:0];

    assign in_key.discipline      = discipline;
    assign in_key.category        = category;
    assign in_key.parameter_id    = parameter_req;
    assign in_key.template_number = template_number;

    sks_ram #(
        .WIDTH (sks_pkg::KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sks_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_kind    (kind),
        .in_index   (entry_index),
        .in_key     (in_key),
        .count      (count),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_status (out_status),
        .out_index  (hit_index),
        .out_key    (out_key)
    );

    assign status         = out_status;
    assign hit_discipline = out_key.discipline;
    assign hit_category   = out_key.category;
    assign hit_parameter  = out_key.parameter_id;
    assign hit_template   = out_key.template_number;

endmodule

`default_nettype wire

/* tb/sorted_key_table_search_tb.sv */
typedef struct packed {
    sks_pkg::status_t status;
    logic [9:0]       hit_idx;
    sks_pkg::key_t    key;
} search_res_t;

class lookup_scoreboard;
    sks_pkg::key_t tbl [sks_pkg::TABLE_DEPTH_DEF];
    logic [10:0]   entry_count;
    search_res_t   awaited [$];
    int            errors;
    int            results_seen;
    int            status_hist [4];

    function new();
        entry_count  = '0;
        errors       = 0;
        results_seen = 0;
        foreach (status_hist[i]) status_hist[i] = 0;
        foreach (tbl[i]) tbl[i] = '0;
    endfunction

    function void set_count(logic [10:0] v);
        entry_count = v;
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    // midpoint binary search, remembering the last probe whose first three keys match
    function search_res_t search(sks_pkg::key_t k);
        search_res_t r;
        int          lo;
        int          hi;
        int          mid;
        int          near_at;
        int          hit_at;
        bit          near_seen;
        bit          exact;
        logic [23:0] want3;
        logic [23:0] have3;
        hi = (entry_count > sks_pkg::TABLE_DEPTH_DEF) ? sks_pkg::TABLE_DEPTH_DEF :
                                                        int'(entry_count);
        lo = 0;
        near_seen = 0;
        exact = 0;
        near_at = 0;
        hit_at = 0;
        want3 = {k.discipline, k.category, k.parameter_id};
        while (lo < hi && !exact)
        begin
            mid = (lo + hi) >> 1;
            have3 = {tbl[mid].discipline, tbl[mid].category, tbl[mid].parameter_id};
            if (want3 < have3)
                hi = mid;
            else if (want3 > have3)
                lo = mid + 1;
            else
            begin
                near_seen = 1;
                near_at = mid;
                if (k.template_number < tbl[mid].template_number)
                    hi = mid;
                else if (k.template_number > tbl[mid].template_number)
                    lo = mid + 1;
                else
                begin
                    exact = 1;
                    hit_at = mid;
                end
            end
        end
        r = '0;
        if (!near_seen)
            r.status = sks_pkg::STAT_NONE;
        else
        begin
            if (exact)
                r.status = sks_pkg::STAT_EXACT;
            else
            begin
                hit_at = near_at;
                r.status = (tbl[hit_at].template_number < k.template_number) ?
                           sks_pkg::STAT_NEAR_LO : sks_pkg::STAT_NEAR_HI;
            end
            r.hit_idx = hit_at[9:0];
            r.key = tbl[hit_at];
        end
        return r;
    endfunction

    function void note_item(logic k, logic [9:0] idx, sks_pkg::key_t key);
        if (k == sks_pkg::KIND_LOAD)
            tbl[idx] = key;
        else
            awaited.push_back(search(key));
    endfunction

    task report(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    task check_result(search_res_t got);
        search_res_t want;
        if (awaited.size() == 0)
        begin
            report("result item with no lookup awaiting it");
            return;
        end
        want = awaited.pop_front();
        results_seen++;
        status_hist[int'(want.status)]++;
        if (got.status !== want.status)
            report($sformatf("result %0d status got %0d expected %0d",
                             results_seen, got.status, want.status));
        if (got.hit_idx !== want.hit_idx)
            report($sformatf("result %0d hit_index got %0d expected %0d",
                             results_seen, got.hit_idx, want.hit_idx));
        if (got.key.discipline !== want.key.discipline)
            report($sformatf("result %0d hit_discipline got %0d expected %0d",
                             results_seen, got.key.discipline, want.key.discipline));
        if (got.key.category !== want.key.category)
            report($sformatf("result %0d hit_category got %0d expected %0d",
                             results_seen, got.key.category, want.key.category));
        if (got.key.parameter_id !== want.key.parameter_id)
            report($sformatf("result %0d hit_parameter got %0d expected %0d",
                             results_seen, got.key.parameter_id, want.key.parameter_id));
        if (got.key.template_number !== want.key.template_number)
            report($sformatf("result %0d hit_template got %0d expected %0d",
                             results_seen, got.key.template_number,
                             want.key.template_number));
    endtask
endclass

module sorted_key_table_search_tb;

    localparam int TB_DEPTH = sks_pkg::TABLE_DEPTH_DEF;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [9:0]  entry_index;
    logic [7:0]  discipline;
    logic [7:0]  category;
    logic [7:0]  parameter_req;
    logic [15:0] template_number;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [9:0]  hit_index;
    logic [7:0]  hit_discipline;
    logic [7:0]  hit_category;
    logic [7:0]  hit_parameter;
    logic [15:0] hit_template;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;

    lookup_scoreboard sb = new();

    sks_pkg::key_t img [TB_DEPTH];
    bit   loaded [TB_DEPTH];
    bit   burst_mode = 0;
    bit   hold_req = 0;
    int   n_loads = 0;
    int   n_lookups = 0;
    int   n_settings = 0;
    int   n_holds = 0;

    sorted_key_table_search u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .entry_index     (entry_index),
        .discipline      (discipline),
        .category        (category),
        .parameter_req   (parameter_req),
        .template_number (template_number),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .hit_index       (hit_index),
        .hit_discipline  (hit_discipline),
        .hit_category    (hit_category),
        .hit_parameter   (hit_parameter),
        .hit_template    (hit_template),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hff;
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] rand_tmpl();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hffff;
        return 16'($urandom);
    endfunction

    function automatic sks_pkg::key_t build_key(logic [7:0] d, logic [7:0] c,
                                                logic [7:0] p, logic [15:0] t);
        sks_pkg::key_t k;
        k.discipline = d;
        k.category = c;
        k.parameter_id = p;
        k.template_number = t;
        return k;
    endfunction

    function automatic sks_pkg::key_t rand_key();
        return build_key(rand_byte(), rand_byte(), rand_byte(), rand_tmpl());
    endfunction

    function automatic int loaded_prefix();
        int i;
        i = 0;
        while (i < TB_DEPTH && loaded[i])
            i++;
        return i;
    endfunction

    // mostly keys taken from the live table, some near misses, some noise
    function automatic sks_pkg::key_t pick_lookup_key(input int n);
        sks_pkg::key_t k;
        int            r;
        r = $urandom_range(0, 99);
        if (n == 0 || r >= 85)
            return rand_key();
        k = img[$urandom_range(0, n - 1)];
        if (r < 40)
            return k;
        if (r < 60)
            k.template_number = $urandom_range(0, 1) ? k.template_number + 16'd1 :
                                                       k.template_number - 16'd1;
        else if (r < 72)
            k.template_number = rand_tmpl();
        else if (r < 78)
            k.template_number = $urandom_range(0, 1) ? 16'h0000 : 16'hffff;
        else
            k.parameter_id = $urandom_range(0, 1) ? k.parameter_id + 8'd1 :
                                                    k.parameter_id - 8'd1;
        return k;
    endfunction

    task automatic send_item(input logic k, input logic [9:0] idx,
                             input sks_pkg::key_t key);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        kind            <= k;
        entry_index     <= idx;
        discipline      <= key.discipline;
        category        <= key.category;
        parameter_req   <= key.parameter_id;
        template_number <= key.template_number;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_item(k, idx, key);
        if (k == sks_pkg::KIND_LOAD)
        begin
            img[idx] = key;
            loaded[idx] = 1;
            n_loads++;
        end
        else
            n_lookups++;
    endtask

    task automatic send_lookup(input sks_pkg::key_t key);
        send_item(sks_pkg::KIND_LOOKUP, 10'($urandom), key);
    endtask

    // a load produces no result, so allow for the block's search latency too
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_count(input logic [10:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_count(v);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic load_sorted_table(input int n, input int ntrip);
        logic [23:0] trips [$];
        logic [39:0] keys [$];
        int          order [$];
        int          j;
        int          tmp;
        bit          narrow;
        logic [15:0] t;
        narrow = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < ntrip; i++)
            trips.push_back({rand_byte(), rand_byte(), rand_byte()});
        for (int i = 0; i < n; i++)
        begin
            t = narrow ? 16'($urandom_range(0, 15)) : rand_tmpl();
            keys.push_back({trips[$urandom_range(0, ntrip - 1)], t});
            order.push_back(i);
        end
        keys.sort();
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[i])
            send_item(sks_pkg::KIND_LOAD, 10'(order[i]), sks_pkg::key_t'(keys[order[i]]));
    endtask

    task automatic run_directed();
        // empty table after reset
        send_lookup(build_key(8'hff, 8'hff, 8'hff, 16'hffff));
        send_lookup(build_key(8'h00, 8'h00, 8'h00, 16'h0000));
        send_item(sks_pkg::KIND_LOAD, 10'd0, build_key(8'h00, 8'h00, 8'h00, 16'h0000));
        send_item(sks_pkg::KIND_LOAD, 10'd1, build_key(8'h10, 8'h20, 8'h30, 16'd100));
        send_item(sks_pkg::KIND_LOAD, 10'd2, build_key(8'h10, 8'h20, 8'h30, 16'd200));
        send_item(sks_pkg::KIND_LOAD, 10'd3, build_key(8'hff, 8'hff, 8'hff, 16'hffff));
        set_count(11'd4);
        send_lookup(build_key(8'h00, 8'h00, 8'h00, 16'h0000));
        send_lookup(build_key(8'hff, 8'hff, 8'hff, 16'hffff));
        send_lookup(build_key(8'h10, 8'h20, 8'h30, 16'd100));
        send_lookup(build_key(8'h10, 8'h20, 8'h30, 16'd150));
        send_lookup(build_key(8'h10, 8'h20, 8'h30, 16'd50));
        send_lookup(build_key(8'h10, 8'h20, 8'h30, 16'hffff));
        send_lookup(build_key(8'h10, 8'h20, 8'h31, 16'd100));
        send_lookup(build_key(8'h10, 8'h20, 8'h29, 16'd0));
        set_count(11'd1);
        send_lookup(build_key(8'h00, 8'h00, 8'h00, 16'h0000));
        send_lookup(build_key(8'h00, 8'h00, 8'h00, 16'hffff));
        set_count(11'd0);
        send_lookup(build_key(8'h00, 8'h00, 8'h00, 16'h0000));
    endtask

    task automatic run_small_phases();
        int n;
        int cnt;
        int r;
        int phase;
        int idx;
        phase = 0;
        while (n_loads + n_lookups < 550)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                n = $urandom_range(1, 16);
            else if (r < 90)
                n = $urandom_range(17, 100);
            else
                n = $urandom_range(101, 200);
            burst_mode = (phase % 4 == 3);
            load_sorted_table(n, $urandom_range(1, 4));
            cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, loaded_prefix()) : n;
            set_count(11'(cnt));
            if (phase == 2)
                hold_req = 1;
            repeat ($urandom_range(20, 60))
            begin
                if ($urandom_range(0, 99) < 12)
                begin
                    // overwrite inside the table (may break the order) or load elsewhere
                    idx = $urandom_range(0, 1) ? $urandom_range(0, n - 1) :
                                                 $urandom_range(0, TB_DEPTH - 1);
                    send_item(sks_pkg::KIND_LOAD, 10'(idx), rand_key());
                end
                else
                    send_lookup(pick_lookup_key(cnt));
            end
            phase++;
        end
        burst_mode = 0;
    endtask

    task automatic run_full_table();
        load_sorted_table(TB_DEPTH, $urandom_range(8, 40));
        set_count(11'(TB_DEPTH));
        hold_req = 1;
        repeat (130) send_lookup(pick_lookup_key(TB_DEPTH));
        // above the table depth: saturates
        set_count(11'h7ff);
        repeat (30) send_lookup(pick_lookup_key(TB_DEPTH));
        set_count(11'(TB_DEPTH - 1));
        repeat (20) send_lookup(pick_lookup_key(TB_DEPTH - 1));
    endtask

    initial
    begin
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(search_res_t'({status, hit_index, hit_discipline,
                                               hit_category, hit_parameter,
                                               hit_template}));
            if (hold_req)
            begin
                hold_req = 0;
                stall_left = 300;
                n_holds++;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (run_left > 0)
            begin
                out_ready <= 1'b1;
                run_left--;
            end
            else
            begin
                stall_left = pick_gap();
                run_left = $urandom_range(1, 24);
                if (stall_left > 0)
                begin
                    out_ready <= 1'b0;
                    stall_left--;
                end
                else
                begin
                    out_ready <= 1'b1;
                    run_left--;
                end
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        kind            = sks_pkg::KIND_LOAD;
        entry_index     = '0;
        discipline      = '0;
        category        = '0;
        parameter_req   = '0;
        template_number = '0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_small_phases();
        run_full_table();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("covered %0d loads and %0d lookups across %0d entry_count writes, %0d %s",
                 n_loads, n_lookups, n_settings, n_holds, "long output stalls");
        $display("lookup outcomes: %0d exact, %0d none, %0d near below, %0d near above; %0d %s",
                 sb.status_hist[sks_pkg::STAT_EXACT], sb.status_hist[sks_pkg::STAT_NONE],
                 sb.status_hist[sks_pkg::STAT_NEAR_LO], sb.status_hist[sks_pkg::STAT_NEAR_HI],
                 sb.errors, "mismatches");
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #32000000;
        $display("timeout: %0d results still awaited", sb.pending());
        $display("TEST FAILED");
        $finish;
    end

endmodule
